@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the cache RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked every cycle outside reset
`define DMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Overlapping implication, checked every cycle outside reset
`define DMC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/dmc_pkg.sv @@
// Shared types and constants of the direct-mapped cache.
// No dependencies; imported by every module of the block.
`default_nettype none

package dmc_pkg;

  // Fixed field widths
  localparam int unsigned ADDR_W    = 12;
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned MISS_W    = 16;
  localparam int unsigned TIME_W    = 24;
  localparam int unsigned TAG_RST_W = 8;

  // Reset values of the cache arrays and registers
  localparam logic [TAG_RST_W-1:0] TAG_RESET    = 8'hFF;
  localparam logic [DATA_W-1:0]    DATA_RESET   = 8'h23;
  localparam logic [CFG_W-1:0]     PENALTY_RST  = 8'd20;
  localparam logic [CFG_W-1:0]     ACC_TIME_RST = 8'd1;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MISS_PENALTY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCESS_TIME  = 2'd1;

  // Function code of the input channel
  localparam logic FUNC_ACCESS = 1'b1;

  // Request queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_ACCESS = 1'b1
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef struct packed {
    logic [CFG_W-1:0] miss_penalty;
    logic [CFG_W-1:0] access_time;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_FILL,
    ST_REQ,
    ST_READ
  } back_st_e;

endpackage

`default_nettype wire

@@ hw/rtl/dmc_front.sv @@
// Front part of the cache: accepts requests, classifies them and queues them.
// Depends on dmc_pkg.
`default_nettype none

module dmc_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        func_i,
  input  logic [dmc_pkg::ADDR_W-1:0]  addr_i,
  input  logic [dmc_pkg::DATA_W-1:0]  wdata_i,
  input  logic                        pop_i,
  output dmc_pkg::head_t              head_o
);
  import dmc_pkg::*;

  item_t             q_mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push;
  item_t             item_in;

  // Classify the incoming request
  always_comb begin
    item_in.op    = (func_i == FUNC_ACCESS) ? OP_ACCESS : OP_LOAD;
    item_in.addr  = addr_i;
    item_in.wdata = wdata_i;
  end

  assign in_ready_o = (cnt_q != QCNT_W'(QDEPTH));
  assign push       = in_valid_i && in_ready_o;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = push  ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Hold queued requests
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= item_in;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = q_mem_q[rd_ptr_q];

endmodule

`default_nettype wire

@@ hw/rtl/dmc_back.sv @@
// Back part of the cache: backing memory, tag and line stores, line fill
// sequencer, counters and the result register. Depends on dmc_pkg.
`default_nettype none
`include "assert_macros.svh"

module dmc_back #(
  parameter int unsigned LINE_SIZE = 16,
  parameter int unsigned NUM_LINES = 8,
  parameter int unsigned MEM_SIZE  = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dmc_pkg::cfg_t               cfg_i,
  input  dmc_pkg::head_t              head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        hit_o,
  output logic [dmc_pkg::DATA_W-1:0]  rdata_o,
  output logic [dmc_pkg::MISS_W-1:0]  miss_total_o,
  output logic [dmc_pkg::TIME_W-1:0]  elapsed_o
);
  import dmc_pkg::*;

  // Address split; sizes are powers of two
  localparam int unsigned OFF_W  = $clog2(LINE_SIZE);
  localparam int unsigned LINE_W = $clog2(NUM_LINES);
  localparam int unsigned MEM_AW = $clog2(MEM_SIZE);
  localparam int unsigned TAG_W  = (ADDR_W > OFF_W + LINE_W + TAG_RST_W) ?
                                   ADDR_W - OFF_W - LINE_W : TAG_RST_W;
  localparam int unsigned EXT_W  = OFF_W + LINE_W + TAG_W;
  localparam int unsigned WIDE_W = (EXT_W > MEM_AW) ? EXT_W : MEM_AW;
  localparam int unsigned DDEPTH = NUM_LINES * LINE_SIZE;
  localparam int unsigned DIDX_W = LINE_W + OFF_W;
  localparam int unsigned CNT_W  = OFF_W + 1;

  // Memories
  logic [DATA_W-1:0] bmem_q     [MEM_SIZE];
  logic [DATA_W-1:0] line_mem_q [DDEPTH];
  logic [TAG_W-1:0]  tag_mem_q  [NUM_LINES];

  back_st_e          state_q, state_d;
  logic [EXT_W-1:0]  addr_q, addr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [OFF_W-1:0]  widx_q, widx_d;
  logic              hit_q, hit_d;
  logic [NUM_LINES-1:0] valid_q, valid_d;
  logic [MISS_W-1:0] miss_q, miss_d;
  logic [TIME_W-1:0] time_q, time_d;

  logic              out_valid_q, out_valid_d;
  logic              out_hit_q;
  logic [DATA_W-1:0] out_rdata_q;
  logic [MISS_W-1:0] out_miss_q;
  logic [TIME_W-1:0] out_time_q;
  logic              out_load;

  logic [DATA_W-1:0] bmem_rd_q, line_rd_q;
  logic [TAG_W-1:0]  tag_rd_q;

  logic              mem_we, mem_re;
  logic [MEM_AW-1:0] mem_addr;
  logic              line_we, line_re;
  logic [DIDX_W-1:0] line_widx, line_ridx;
  logic              tag_we, tag_re;
  logic [LINE_W-1:0] tag_ridx;

  logic [EXT_W-1:0]  head_ext;
  logic [WIDE_W-1:0] ld_wide, fill_wide;
  logic [OFF_W-1:0]  fill_off;
  logic [OFF_W-1:0]  cur_word;
  logic [LINE_W-1:0] cur_line;
  logic [TAG_W-1:0]  cur_tag, eff_tag;
  logic [TIME_W-1:0] time_acc;

  function automatic logic [TIME_W-1:0] time_sat(input logic [TIME_W-1:0] t,
                                                 input logic [CFG_W-1:0]  d);
    logic [TIME_W:0] s;
    s = {1'b0, t} + (TIME_W+1)'(d);
    return s[TIME_W] ? '1 : s[TIME_W-1:0];
  endfunction

  // Split the working and queued addresses
  assign head_ext  = EXT_W'(head_i.item.addr);
  assign cur_word  = addr_q[OFF_W-1:0];
  assign cur_line  = addr_q[OFF_W +: LINE_W];
  assign cur_tag   = addr_q[EXT_W-1 -: TAG_W];
  assign fill_off  = (state_q == ST_LOOKUP) ? '0 : cnt_q[OFF_W-1:0];
  assign ld_wide   = WIDE_W'(head_ext);
  assign fill_wide = WIDE_W'({addr_q[EXT_W-1:OFF_W], fill_off});
  assign eff_tag   = valid_q[cur_line] ? tag_rd_q : TAG_W'(TAG_RESET);
  assign time_acc  = time_sat(time_q, cfg_i.access_time);
  assign out_load  = (state_q == ST_READ) && (!out_valid_q || out_ready_i);

  // Sequence lookup, fill and result
  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    cnt_d     = cnt_q;
    widx_d    = widx_q;
    hit_d     = hit_q;
    valid_d   = valid_q;
    miss_d    = miss_q;
    time_d    = time_q;
    pop_o     = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = fill_wide[MEM_AW-1:0];
    line_we   = 1'b0;
    line_re   = 1'b0;
    line_widx = {cur_line, widx_q};
    line_ridx = {cur_line, cur_word};
    tag_we    = 1'b0;
    tag_re    = 1'b0;
    tag_ridx  = head_ext[OFF_W +: LINE_W];
    unique case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          if (head_i.item.op == OP_LOAD) begin
            mem_we   = 1'b1;
            mem_addr = ld_wide[MEM_AW-1:0];
          end else begin
            tag_re  = 1'b1;
            addr_d  = head_ext;
            state_d = ST_LOOKUP;
          end
        end
      end
      ST_LOOKUP: begin
        hit_d = (eff_tag == cur_tag);
        if (eff_tag == cur_tag) begin
          line_re = 1'b1;
          state_d = ST_READ;
        end else begin
          if (miss_q != '1) begin
            miss_d = miss_q + MISS_W'(1);
          end
          time_d  = time_sat(time_q, cfg_i.miss_penalty);
          mem_re  = 1'b1;
          widx_d  = '0;
          cnt_d   = CNT_W'(1);
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        // Write the byte read last cycle, fetch the next one
        line_we = 1'b1;
        if (cnt_q == CNT_W'(LINE_SIZE)) begin
          tag_we            = 1'b1;
          valid_d[cur_line] = 1'b1;
          state_d           = ST_REQ;
        end else begin
          mem_re = 1'b1;
          widx_d = cnt_q[OFF_W-1:0];
          cnt_d  = cnt_q + CNT_W'(1);
        end
      end
      ST_REQ: begin
        line_re = 1'b1;
        state_d = ST_READ;
      end
      ST_READ: begin
        if (out_load) begin
          time_d  = time_acc;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      miss_q      <= '0;
      time_q      <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      miss_q      <= miss_d;
      time_q      <= time_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  // Hold working payload
  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    widx_q <= widx_d;
    hit_q  <= hit_d;
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_hit_q   <= hit_q;
      out_rdata_q <= valid_q[cur_line] ? line_rd_q : DATA_RESET;
      out_miss_q  <= miss_q;
      out_time_q  <= time_acc;
    end
  end

  // Backing memory, one port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bmem_q[mem_addr] <= head_i.item.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      bmem_rd_q <= bmem_q[mem_addr];
    end
  end

  // Line data store
  always_ff @(posedge clk_i) begin
    if (line_we) begin
      line_mem_q[line_widx] <= bmem_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (line_re) begin
      line_rd_q <= line_mem_q[line_ridx];
    end
  end

  // Tag store
  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem_q[cur_line] <= cur_tag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_re) begin
      tag_rd_q <= tag_mem_q[tag_ridx];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = out_hit_q;
  assign rdata_o      = out_rdata_q;
  assign miss_total_o = out_miss_q;
  assign elapsed_o    = out_time_q;

  `DMC_ASSERT_IMP(a_pop_needs_head, pop_o, head_i.valid, "pop from empty request queue")
  `DMC_ASSERT(a_miss_monotone, miss_q >= $past(miss_q), "miss counter went backwards")
  `DMC_ASSERT(a_time_monotone, time_q >= $past(time_q), "time counter went backwards")
  `DMC_ASSERT_IMP(a_fill_count, state_q == ST_FILL, cnt_q != '0 && cnt_q <= CNT_W'(LINE_SIZE), "fill count out of range")

endmodule

`default_nettype wire

@@ hw/rtl/direct_mapped_cache_with_fill.sv @@
// Top level of the direct-mapped read-only byte cache with its backing memory.
// Depends on dmc_pkg, dmc_front and dmc_back.
//
// Input channel (in_valid_i/in_ready_o): func_i = 0 writes wdata_i into backing
// memory at addr_i and gives no result; func_i = 1 reads the cached byte at
// addr_i and gives one result on the output channel (out_valid_o/out_ready_i):
// hit flag, byte, running miss count and elapsed time, both saturating.
// Configuration channel (cfg_valid_i/cfg_ready_o): index 0 sets the miss
// penalty, index 1 the access time; other indexes are ignored. Always ready.
// A two-entry request queue sits between the accepting front and the back
// sequencer. Loads retire one per cycle while the back sequencer is idle. A hit
// passes the back sequencer through lookup and read; a miss adds a line fill,
// one byte per cycle from the single-port backing memory, and a request state.
// The back sequencer takes the next request once the result is registered.
// Reset clears the line valid bits at once (tags read as 0xFF, data as 0x23),
// the counters and the queue; backing memory is undefined until written.
// When the receiver stalls the result waits in the output register; the
// queue keeps taking requests until it is full.

`default_nettype none

module direct_mapped_cache_with_fill #(
  parameter int unsigned LINE_SIZE = 16,
  parameter int unsigned NUM_LINES = 8,
  parameter int unsigned MEM_SIZE  = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic [dmc_pkg::ADDR_W-1:0]    addr_i,
  input  logic [dmc_pkg::DATA_W-1:0]    wdata_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  output logic [dmc_pkg::DATA_W-1:0]    rdata_o,
  output logic [dmc_pkg::MISS_W-1:0]    miss_total_o,
  output logic [dmc_pkg::TIME_W-1:0]    elapsed_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dmc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dmc_pkg::CFG_W-1:0]     cfg_data_i
);
  import dmc_pkg::*;

  cfg_t  cfg_q, cfg_d;
  head_t head;
  logic  pop;

  assign cfg_ready_o = 1'b1;

  // Decode configuration writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MISS_PENALTY: cfg_d.miss_penalty = cfg_data_i;
        REG_ACCESS_TIME:  cfg_d.access_time  = cfg_data_i;
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.miss_penalty <= PENALTY_RST;
      cfg_q.access_time  <= ACC_TIME_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dmc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .addr_i     (addr_i),
    .wdata_i    (wdata_i),
    .pop_i      (pop),
    .head_o     (head)
  );

  dmc_back #(
    .LINE_SIZE (LINE_SIZE),
    .NUM_LINES (NUM_LINES),
    .MEM_SIZE  (MEM_SIZE)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hit_o        (hit_o),
    .rdata_o      (rdata_o),
    .miss_total_o (miss_total_o),
    .elapsed_o    (elapsed_o)
  );

endmodule

`default_nettype wire

@@ tb/direct_mapped_cache_with_fill_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of direct_mapped_cache_with_fill: a cache scoreboard
// predicts every read result and checks it field by field against the block.
// Depends on dmc_pkg and the cache RTL; drives all three channels itself.

module direct_mapped_cache_with_fill_test;
  import dmc_pkg::*;

  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES   = 8;
  localparam int unsigned CYCLE_LIMIT    = 5_000_000;
  localparam int unsigned SETTLE_CYCLES  = 32;
  localparam int unsigned PHASE_ITEMS    = 250;
  localparam int unsigned BLOCK_BYTES    = 16;
  localparam int unsigned NUM_BLOCKS     = 256;
  localparam int unsigned MEM_BYTES      = 4096;
  localparam int unsigned LINE_COUNT     = 8;
  localparam int unsigned MAX_WAIT       = 19;
  localparam int unsigned PINGPONG_ITEMS = 48;

  // indexes past the register list, ignored by the block
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam logic [MISS_W-1:0]    MISS_SAT     = '1;
  localparam logic [TIME_W-1:0]    TIME_SAT     = '1;
  localparam logic [CFG_W-1:0]     CFG_MAX      = '1;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] rdata;
    logic [MISS_W-1:0] miss_total;
    logic [TIME_W-1:0] elapsed;
  } read_result_t;

  // Cache state mirror and the queue of reads still to come back
  class cache_scoreboard;
    logic [TAG_RST_W-1:0] tag_mem [LINE_COUNT];
    logic [DATA_W-1:0]    line_mem [LINE_COUNT * BLOCK_BYTES];
    logic [DATA_W-1:0]    backing [MEM_BYTES];
    bit                   written [MEM_BYTES];
    int unsigned          block_count [NUM_BLOCKS];
    logic [MISS_W-1:0]    miss_cnt;
    logic [TIME_W-1:0]    time_cnt;
    logic [CFG_W-1:0]     penalty;
    logic [CFG_W-1:0]     acc_time;
    read_result_t         expected_reads [$];
    int unsigned          errors;

    function new();
      foreach (tag_mem[i]) tag_mem[i] = TAG_RESET;
      foreach (line_mem[i]) line_mem[i] = DATA_RESET;
      foreach (backing[i]) begin
        backing[i] = '0;
        written[i] = 1'b0;
      end
      foreach (block_count[i]) block_count[i] = 0;
      miss_cnt = '0;
      time_cnt = '0;
      penalty  = PENALTY_RST;
      acc_time = ACC_TIME_RST;
      errors   = 0;
    endfunction

    function logic [TIME_W-1:0] time_plus(logic [TIME_W-1:0] t, logic [CFG_W-1:0] d);
      logic [TIME_W:0] s;
      s = {1'b0, t} + {{(TIME_W + 1 - CFG_W){1'b0}}, d};
      return s[TIME_W] ? TIME_SAT : s[TIME_W-1:0];
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_MISS_PENALTY: penalty = val;
        REG_ACCESS_TIME:  acc_time = val;
        default: ;
      endcase
    endfunction

    function bit resident(logic [ADDR_W-1:0] addr);
      return tag_mem[addr[6:4]] == {3'b000, addr[11:7]};
    endfunction

    // a read may only miss on a block whose every byte has been loaded
    function bit fill_safe(logic [ADDR_W-1:0] addr);
      return resident(addr) || block_count[addr[11:4]] == BLOCK_BYTES;
    endfunction

    function void note_request(op_e op, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] wdata);
      read_result_t r;
      int unsigned  line;
      int unsigned  base;
      if (op == OP_LOAD) begin
        if (!written[addr]) begin
          written[addr] = 1'b1;
          block_count[addr[11:4]]++;
        end
        backing[addr] = wdata;
        return;
      end
      line  = 32'(addr[6:4]);
      base  = 32'({addr[11:4], 4'b0000});
      r.hit = resident(addr);
      // on a miss count it, charge the penalty and refill the whole line
      if (!r.hit) begin
        if (miss_cnt != MISS_SAT) miss_cnt++;
        time_cnt = time_plus(time_cnt, penalty);
        for (int k = 0; k < BLOCK_BYTES; k++) begin
          line_mem[line * BLOCK_BYTES + k] = backing[(base + k) % MEM_BYTES];
        end
        tag_mem[line] = {3'b000, addr[11:7]};
      end
      time_cnt     = time_plus(time_cnt, acc_time);
      r.rdata      = line_mem[line * BLOCK_BYTES + addr[3:0]];
      r.miss_total = miss_cnt;
      r.elapsed    = time_cnt;
      expected_reads.push_back(r);
    endfunction

    function void check_read(logic hit, logic [DATA_W-1:0] rdata,
                             logic [MISS_W-1:0] miss_total, logic [TIME_W-1:0] elapsed);
      read_result_t want;
      if (expected_reads.size() == 0) begin
        $error("read result with no read outstanding: rdata %0h", rdata);
        errors++;
        return;
      end
      want = expected_reads.pop_front();
      if (hit !== want.hit) begin
        $error("hit: expected %0d, got %0d", want.hit, hit);
        errors++;
      end
      if (rdata !== want.rdata) begin
        $error("rdata: expected %0h, got %0h", want.rdata, rdata);
        errors++;
      end
      if (miss_total !== want.miss_total) begin
        $error("miss_total: expected %0d, got %0d", want.miss_total, miss_total);
        errors++;
      end
      if (elapsed !== want.elapsed) begin
        $error("elapsed: expected %0d, got %0d", want.elapsed, elapsed);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_reads.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 func_i;
  logic [ADDR_W-1:0]    addr_i;
  logic [DATA_W-1:0]    wdata_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic                 hit_o;
  logic [DATA_W-1:0]    rdata_o;
  logic [MISS_W-1:0]    miss_total_o;
  logic [TIME_W-1:0]    elapsed_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;

  cache_scoreboard sb;
  int unsigned     cycle_count = 0;
  int unsigned     send_gap_max = MAX_WAIT;
  int unsigned     recv_stall_max = MAX_WAIT;
  logic [4:0]      hot_tags [4] = '{5'd0, 5'd31, 5'd9, 5'd22};

  direct_mapped_cache_with_fill i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .addr_i       (addr_i),
    .wdata_i      (wdata_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hit_o        (hit_o),
    .rdata_o      (rdata_o),
    .miss_total_o (miss_total_o),
    .elapsed_o    (elapsed_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $error("timed out after %0d cycles", cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offer one request after a random gap and hold it until taken
  task automatic send_request(input op_e op, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] wdata);
    int unsigned gap;
    gap = $urandom_range(send_gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= op;
    addr_i     <= addr;
    wdata_i    <= wdata;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(op, addr, wdata);
  endtask

  // Drop valid and wait until every read has come back
  task automatic hold_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Drain, then give trailing loads time to retire
  task automatic settle();
    hold_input();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write both registers back to back, optionally with writes to spare indexes
  task automatic program_registers(input logic [CFG_W-1:0] penalty,
                                   input logic [CFG_W-1:0] acc, input bit spare);
    logic [CFG_IDX_W-1:0] idx_q [$];
    logic [CFG_W-1:0]     val_q [$];
    if (spare) begin
      idx_q.push_back(REG_SPARE_LO);
      val_q.push_back(CFG_W'($urandom));
      idx_q.push_back(REG_SPARE_HI);
      val_q.push_back(CFG_W'($urandom));
    end
    idx_q.push_back(REG_MISS_PENALTY);
    val_q.push_back(penalty);
    idx_q.push_back(REG_ACCESS_TIME);
    val_q.push_back(acc);
    foreach (idx_q[i]) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx_q[i];
      cfg_data_i  <= val_q[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      sb.set_register(idx_q[i], val_q[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Load every byte of one 16-byte block with random data
  task automatic fill_block(input logic [7:0] blk);
    logic [ADDR_W-1:0] a;
    for (int k = 0; k < BLOCK_BYTES; k++) begin
      a = {blk, 4'(k)};
      send_request(OP_LOAD, a, DATA_W'($urandom));
    end
  endtask

  // Mostly a few hot tags so that hits and conflict misses both occur
  function automatic logic [ADDR_W-1:0] pick_address();
    logic [ADDR_W-1:0] a;
    logic [6:0]        low;
    a   = ADDR_W'($urandom_range(MEM_BYTES - 1));
    low = 7'($urandom);
    if ($urandom_range(3) != 0) a = {hot_tags[$urandom_range(3)], low};
    return a;
  endfunction

  function automatic logic [ADDR_W-1:0] first_unloaded(logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] p;
    for (int k = 0; k < BLOCK_BYTES; k++) begin
      p = {a[11:4], 4'(k)};
      if (!sb.written[p]) return p;
    end
    return a;
  endfunction

  // 20% random loads; else read where fill is safe, else load the block bytewise
  task automatic random_request();
    logic [ADDR_W-1:0] a;
    logic [DATA_W-1:0] d;
    a = pick_address();
    d = DATA_W'($urandom);
    if ($urandom_range(99) < 20) begin
      send_request(OP_LOAD, a, d);
    end else if (sb.fill_safe(a)) begin
      send_request(OP_ACCESS, a, d);
    end else begin
      send_request(OP_LOAD, first_unloaded(a), d);
    end
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] penalty, input logic [CFG_W-1:0] acc,
                           input int unsigned send_max, input int unsigned recv_max,
                           input bit spare);
    settle();
    program_registers(penalty, acc, spare);
    send_gap_max   = send_max;
    recv_stall_max = recv_max;
    hot_tags[2]    = 5'($urandom);
    hot_tags[3]    = 5'($urandom);
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      // pause half-way until the cache has answered everything
      if (n == PHASE_ITEMS / 2) hold_input();
      random_request();
    end
  endtask

  // Ping-pong two blocks on one line, largest settings: only the first may hit
  task automatic conflict_ping_pong();
    logic [ADDR_W-1:0] a;
    logic [3:0]        w;
    bit                upper;
    settle();
    program_registers(CFG_MAX, CFG_MAX, 1'b0);
    send_gap_max   = 0;
    recv_stall_max = 0;
    fill_block(8'h07);
    fill_block(8'hFF);
    upper = 1'b0;
    for (int n = 0; n < PINGPONG_ITEMS; n++) begin
      upper = ~upper;
      w     = 4'($urandom);
      a     = {(upper ? 8'hFF : 8'h07), w};
      send_request(OP_ACCESS, a, DATA_W'($urandom));
    end
  endtask

  // Accept results after a random stall and check each one
  initial begin : result_sink
    int unsigned stall;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = $urandom_range(recv_stall_max);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      sb.check_read(hit_o, rdata_o, miss_total_o, elapsed_o);
    end
  end

  initial begin : stimulus
    logic [DATA_W-1:0] b;
    sb = new();
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    func_i      <= OP_LOAD;
    addr_i      <= '0;
    wdata_i     <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= REG_MISS_PENALTY;
    cfg_data_i  <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: load block 0 from 0x00 to 0xFF, read its ends at reset settings
    for (int k = 0; k < BLOCK_BYTES; k++) begin
      b = DATA_W'(k);
      send_request(OP_LOAD, ADDR_W'(k), b * 8'h11);
    end
    send_request(OP_ACCESS, 12'h000, 8'h00);
    send_request(OP_ACCESS, 12'h00F, 8'hFF);
    // the cache does not see later loads: the stale byte must come back
    send_request(OP_LOAD, 12'h005, 8'h5A);
    send_request(OP_ACCESS, 12'h005, 8'hA5);
    send_request(OP_LOAD, 12'hFFF, 8'hFF);

    // Random phases across register extremes and idling patterns
    run_phase(8'd0, 8'd0, MAX_WAIT, MAX_WAIT, 1'b1);
    run_phase(CFG_MAX, CFG_MAX, 0, 0, 1'b0);
    run_phase(8'd0, CFG_MAX, MAX_WAIT, 0, 1'b1);
    run_phase(CFG_MAX, 8'd0, 0, MAX_WAIT, 1'b0);
    run_phase(CFG_W'($urandom), CFG_W'($urandom), MAX_WAIT, MAX_WAIT, 1'b1);
    run_phase(CFG_W'($urandom), CFG_W'($urandom), MAX_WAIT, 0, 1'b0);
    conflict_ping_pong();

    // Drain and give stray results a chance to show up
    hold_input();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ direct_mapped_cache_with_fill.f @@
+incdir+hw/rtl
hw/rtl/dmc_pkg.sv
hw/rtl/dmc_front.sv
hw/rtl/dmc_back.sv
hw/rtl/direct_mapped_cache_with_fill.sv
tb/direct_mapped_cache_with_fill_test.sv
